// ===== rtl/core/swimmer_shear_flow_tangent_rhs_core_macros.svh =====
// Assertion macros for the swimmer shear flow tangent core
`ifndef SWIMMER_SHEAR_FLOW_TANGENT_RHS_CORE_MACROS_SVH
`define SWIMMER_SHEAR_FLOW_TANGENT_RHS_CORE_MACROS_SVH

// condition implies consequence in the same cycle
`define SSFTR_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("ssftr assertion failed");

// condition implies consequence in the next cycle
`define SSFTR_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("ssftr assertion failed");

`endif

// ===== rtl/core/ssftr_pkg.sv =====
// Shared types, constants and helpers for the swimmer shear flow tangent core
package ssftr_pkg;

    localparam int DATA_WIDTH   = 32;
    localparam int SAT_W        = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
    localparam int CORDIC_STEPS = 24;
    localparam int CW           = 34;   // CORDIC datapath width
    localparam int AW           = 66;   // accumulation width
    localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

    typedef enum logic [2:0] {
        REG_ONE_OVER_PSI = 3'd0,
        REG_SWIM_RATIO   = 3'd1,
        REG_PHASE_OFFSET = 3'd2,
        REG_FLOW_SELECT  = 3'd3
    } t_reg_idx;

    typedef struct packed {
        logic            vld;
        logic [31:0]     phase;
        logic [31:0]     heading;
        logic [8:0][31:0] v;
    } t_item;

    typedef struct packed {
        logic signed [31:0] one_over_psi;
        logic signed [31:0] swim_ratio;
        logic               flow_select;
    } t_cfg;

    function automatic logic signed [CW-1:0] atan_val(input logic [4:0] i);
        logic signed [CW-1:0] r;
        case (i)
            5'd0:  r = 34'sh020000000;
            5'd1:  r = 34'sh012E4051E;
            5'd2:  r = 34'sh009FB385B;
            5'd3:  r = 34'sh0051111D4;
            5'd4:  r = 34'sh0028B0D43;
            5'd5:  r = 34'sh00145D7E1;
            5'd6:  r = 34'sh000A2F61E;
            5'd7:  r = 34'sh000517C55;
            5'd8:  r = 34'sh00028BE53;
            5'd9:  r = 34'sh000145F2F;
            5'd10: r = 34'sh0000A2F98;
            5'd11: r = 34'sh0000517CC;
            5'd12: r = 34'sh000028BE6;
            5'd13: r = 34'sh0000145F3;
            5'd14: r = 34'sh00000A2FA;
            5'd15: r = 34'sh00000517D;
            5'd16: r = 34'sh0000028BE;
            5'd17: r = 34'sh00000145F;
            5'd18: r = 34'sh000000A30;
            5'd19: r = 34'sh000000518;
            5'd20: r = 34'sh00000028C;
            5'd21: r = 34'sh000000146;
            5'd22: r = 34'sh0000000A3;
            5'd23: r = 34'sh000000051;
            default: r = '0;
        endcase
        return r;
    endfunction

    // round half up by s bits, then saturate to SAT_W and sign-extend to 32
    function automatic logic signed [31:0] rnd_sat(input logic signed [AW-1:0] v, input int s);
        logic signed [AW-1:0] one_c;
        logic signed [AW-1:0] t;
        logic signed [AW-1:0] hi;
        logic signed [AW-1:0] lo;
        logic signed [AW-1:0] r;
        one_c = 1;
        t  = (v + (one_c <<< (s - 1))) >>> s;
        hi = (one_c <<< (SAT_W - 1)) - one_c;
        lo = -hi - one_c;
        if (t > hi) r = hi;
        else if (t < lo) r = lo;
        else r = t;
        return r[31:0];
    endfunction

endpackage

// ===== rtl/core/swimmer_shear_flow_tangent_rhs_core.sv =====
// Top level of the swimmer shear flow right-hand side and tangent core
// One request is taken per clock: a request is accepted when i_start is high
// and o_busy is low, and o_busy stays low in normal use because the back end
// drains its two-entry front queue every cycle. Each request gives one result,
// presented for a single cycle with o_strobe high, after passing through the
// queue, a fold stage, the 24-stage CORDIC pipelines (one
// rotation per stage, phase and heading side by side), a rounding stage and
// four product/sum stages. The receiver cannot stall, so results must be taken
// when strobed. Configuration (1/Psi, F, phase offset sigma, flow select)
// is written through i_cfg_we/i_cfg_idx/i_cfg_data and must only change while
// no request is in flight; writes to unknown indexes are dropped.
`include "swimmer_shear_flow_tangent_rhs_core_macros.svh"

module swimmer_shear_flow_tangent_rhs_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic [31:0] i_flow_coord,
    input  logic [31:0] i_heading,
    input  logic signed [31:0] i_v1_x,
    input  logic signed [31:0] i_v1_y,
    input  logic signed [31:0] i_v1_a,
    input  logic signed [31:0] i_v2_x,
    input  logic signed [31:0] i_v2_y,
    input  logic signed [31:0] i_v2_a,
    input  logic signed [31:0] i_v3_x,
    input  logic signed [31:0] i_v3_y,
    input  logic signed [31:0] i_v3_a,
    output logic        o_strobe,
    output logic signed [31:0] o_vel_x,
    output logic signed [31:0] o_vel_y,
    output logic signed [31:0] o_turn_rate,
    output logic signed [31:0] o_dv1_x,
    output logic signed [31:0] o_dv1_y,
    output logic signed [31:0] o_dv1_a,
    output logic signed [31:0] o_dv2_x,
    output logic signed [31:0] o_dv2_y,
    output logic signed [31:0] o_dv2_a,
    output logic signed [31:0] o_dv3_x,
    output logic signed [31:0] o_dv3_y,
    output logic signed [31:0] o_dv3_a
);

    // configuration registers
    ssftr_pkg::t_cfg r_cfg;
    logic [31:0]     r_phase_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.one_over_psi <= '0;
            r_cfg.swim_ratio   <= '0;
            r_cfg.flow_select  <= 1'b1;
            r_phase_offset     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ssftr_pkg::REG_ONE_OVER_PSI: r_cfg.one_over_psi <= $signed(i_cfg_data);
                ssftr_pkg::REG_SWIM_RATIO:   r_cfg.swim_ratio   <= $signed(i_cfg_data);
                ssftr_pkg::REG_PHASE_OFFSET: r_phase_offset     <= i_cfg_data;
                ssftr_pkg::REG_FLOW_SELECT:  r_cfg.flow_select  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // front: accept and queue
    ssftr_pkg::t_item q_item;
    logic             pop;
    logic [8:0][31:0] vin;
    assign vin = {i_v3_a, i_v3_y, i_v3_x, i_v2_a, i_v2_y, i_v2_x, i_v1_a, i_v1_y, i_v1_x};

    ssftr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_phase_offset (r_phase_offset),
        .i_flow_coord   (i_flow_coord),
        .i_heading      (i_heading),
        .i_v            (vin),
        .i_pop          (pop),
        .o_busy         (o_busy),
        .o_item         (q_item)
    );

    // back: sin/cos and derivatives
    logic [11:0][31:0] res;

    ssftr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (q_item),
        .i_cfg    (r_cfg),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_res    (res)
    );

    assign o_vel_x     = $signed(res[0]);
    assign o_vel_y     = $signed(res[1]);
    assign o_turn_rate = $signed(res[2]);
    assign o_dv1_x     = $signed(res[3]);
    assign o_dv1_y     = $signed(res[4]);
    assign o_dv1_a     = $signed(res[5]);
    assign o_dv2_x     = $signed(res[6]);
    assign o_dv2_y     = $signed(res[7]);
    assign o_dv2_a     = $signed(res[8]);
    assign o_dv3_x     = $signed(res[9]);
    assign o_dv3_y     = $signed(res[10]);
    assign o_dv3_a     = $signed(res[11]);

    // an accepted request is visible at the queue head next cycle
    `SSFTR_ASSERT_NEXT(a_accept_queued, i_clk, i_rst_n, i_start && !o_busy, q_item.vld)
    // the back end drains the queue every cycle, so it never fills
    `SSFTR_ASSERT_IMPL(a_never_busy, i_clk, i_rst_n, q_item.vld, !o_busy)
    // nothing leaves the pipe right after reset
    `SSFTR_ASSERT_NEXT(a_reset_quiet, i_clk, 1'b1, !i_rst_n, !o_strobe)

endmodule

// ===== rtl/core/ssftr_front.sv =====
// Front end: request acceptance, phase offset and a two-entry queue
module ssftr_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [31:0]          i_phase_offset,
    input  logic [31:0]          i_flow_coord,
    input  logic [31:0]          i_heading,
    input  logic [8:0][31:0]     i_v,
    input  logic                 i_pop,
    output logic                 o_busy,
    output ssftr_pkg::t_item     o_item
);

    ssftr_pkg::t_item r_q [2];
    logic             r_wr, r_rd;
    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;
    logic             push, pop;

    assign o_busy = (r_cnt == 2'd2);
    assign push   = i_start && !o_busy;
    assign pop    = i_pop && (r_cnt != 2'd0);

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) n_cnt = r_cnt + 2'd1;
        else if (pop && !push) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) r_wr <= ~r_wr;
            if (pop) r_rd <= ~r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr].vld     <= 1'b1;
            r_q[r_wr].phase   <= i_flow_coord + i_phase_offset;
            r_q[r_wr].heading <= i_heading;
            r_q[r_wr].v       <= i_v;
        end
    end

    always_comb begin
        o_item     = r_q[r_rd];
        o_item.vld = (r_cnt != 2'd0);
    end

endmodule

// ===== rtl/core/ssftr_back.sv =====
// Back end: CORDIC sin/cos pipelines, coefficient and tangent products
module ssftr_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ssftr_pkg::t_item     i_item,
    input  ssftr_pkg::t_cfg      i_cfg,
    output logic                 o_pop,
    output logic                 o_strobe,
    output logic [11:0][31:0]    o_res
);

    localparam int NS = ssftr_pkg::CORDIC_STEPS;
    localparam int CW = ssftr_pkg::CW;
    localparam int AW = ssftr_pkg::AW;

    // back end never stalls
    assign o_pop = 1'b1;

    logic                 r_vld [NS+6];
    logic [8:0][31:0]     r_v   [NS+4];
    logic signed [CW-1:0] r_px [NS+1], r_py [NS+1], r_pz [NS+1];
    logic signed [CW-1:0] r_ax [NS+1], r_ay [NS+1], r_az [NS+1];
    logic                 r_pf [NS+1], r_af [NS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NS + 6; i++) r_vld[i] <= 1'b0;
        end else begin
            r_vld[0] <= i_item.vld;
            for (int i = 1; i < NS + 6; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_v[0] <= i_item.v;
        for (int i = 1; i < NS + 4; i++) r_v[i] <= r_v[i-1];
    end

    // fold into [-pi/2, pi/2]
    logic signed [CW-1:0] zp, za;
    assign zp = CW'($signed(i_item.phase));
    assign za = CW'($signed(i_item.heading));

    always_ff @(posedge i_clk) begin
        r_px[0] <= ssftr_pkg::CORDIC_X0;
        r_py[0] <= '0;
        r_ax[0] <= ssftr_pkg::CORDIC_X0;
        r_ay[0] <= '0;
        unique case (i_item.phase[31:30])
            2'b01:   begin r_pz[0] <= zp - (CW'(1) <<< 31); r_pf[0] <= 1'b1; end
            2'b10:   begin r_pz[0] <= zp + (CW'(1) <<< 31); r_pf[0] <= 1'b1; end
            default: begin r_pz[0] <= zp;                   r_pf[0] <= 1'b0; end
        endcase
        unique case (i_item.heading[31:30])
            2'b01:   begin r_az[0] <= za - (CW'(1) <<< 31); r_af[0] <= 1'b1; end
            2'b10:   begin r_az[0] <= za + (CW'(1) <<< 31); r_af[0] <= 1'b1; end
            default: begin r_az[0] <= za;                   r_af[0] <= 1'b0; end
        endcase
    end

    for (genvar g = 0; g < NS; g++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            r_pf[g+1] <= r_pf[g];
            r_af[g+1] <= r_af[g];
            if (!r_pz[g][CW-1]) begin
                r_px[g+1] <= r_px[g] - (r_py[g] >>> g);
                r_py[g+1] <= r_py[g] + (r_px[g] >>> g);
                r_pz[g+1] <= r_pz[g] - ssftr_pkg::atan_val(5'(g));
            end else begin
                r_px[g+1] <= r_px[g] + (r_py[g] >>> g);
                r_py[g+1] <= r_py[g] - (r_px[g] >>> g);
                r_pz[g+1] <= r_pz[g] + ssftr_pkg::atan_val(5'(g));
            end
            if (!r_az[g][CW-1]) begin
                r_ax[g+1] <= r_ax[g] - (r_ay[g] >>> g);
                r_ay[g+1] <= r_ay[g] + (r_ax[g] >>> g);
                r_az[g+1] <= r_az[g] - ssftr_pkg::atan_val(5'(g));
            end else begin
                r_ax[g+1] <= r_ax[g] + (r_ay[g] >>> g);
                r_ay[g+1] <= r_ay[g] - (r_ax[g] >>> g);
                r_az[g+1] <= r_az[g] + ssftr_pkg::atan_val(5'(g));
            end
        end
    end

    // unfold and round Q4.30 to Q8.24
    logic signed [CW-1:0] ucp, usp, uca, usa;
    logic signed [31:0]   r_cp, r_sp, r_ca, r_sa;
    always_comb begin
        ucp = r_pf[NS] ? -r_px[NS] : r_px[NS];
        usp = r_pf[NS] ? -r_py[NS] : r_py[NS];
        uca = r_af[NS] ? -r_ax[NS] : r_ax[NS];
        usa = r_af[NS] ? -r_ay[NS] : r_ay[NS];
    end
    always_ff @(posedge i_clk) begin
        r_cp <= 32'((ucp + CW'(32)) >>> 6);
        r_sp <= 32'((usp + CW'(32)) >>> 6);
        r_ca <= 32'((uca + CW'(32)) >>> 6);
        r_sa <= 32'((usa + CW'(32)) >>> 6);
    end

    // first products
    logic signed [63:0] r_fsa, r_fca, r_rsa, r_rca;
    logic signed [31:0] r_cp1, r_sp1;
    always_ff @(posedge i_clk) begin
        r_fsa <= 64'(i_cfg.swim_ratio) * 64'(r_sa);
        r_fca <= 64'(i_cfg.swim_ratio) * 64'(r_ca);
        r_rsa <= 64'(i_cfg.one_over_psi) * 64'(r_sa);
        r_rca <= 64'(i_cfg.one_over_psi) * 64'(r_ca);
        r_cp1 <= r_cp;
        r_sp1 <= r_sp;
    end

    // coefficients and velocities
    logic signed [AW-1:0] cp_w, sp_w, fsa_w, fca_w;
    logic signed [31:0]   n_vx, n_vy, n_tr;
    always_comb begin
        cp_w  = AW'(r_cp1) <<< 24;
        sp_w  = AW'(r_sp1) <<< 24;
        fsa_w = AW'(r_fsa);
        fca_w = AW'(r_fca);
        if (i_cfg.flow_select) begin
            n_vx = ssftr_pkg::rnd_sat(cp_w + fca_w, 24);
            n_vy = ssftr_pkg::rnd_sat(fsa_w, 24);
        end else begin
            n_vx = ssftr_pkg::rnd_sat(fca_w, 24);
            n_vy = ssftr_pkg::rnd_sat(cp_w + fsa_w, 24);
        end
        n_tr = ssftr_pkg::rnd_sat(AW'(r_rca) - sp_w, 25);
    end

    logic signed [31:0] r_fs, r_fc, r_rs, r_cp2, r_sp2;
    logic signed [31:0] r_vel [2][3];
    always_ff @(posedge i_clk) begin
        r_fs  <= ssftr_pkg::rnd_sat(fsa_w, 24);
        r_fc  <= ssftr_pkg::rnd_sat(fca_w, 24);
        r_rs  <= ssftr_pkg::rnd_sat(AW'(r_rsa), 24);
        r_cp2 <= r_cp1;
        r_sp2 <= r_sp1;
        r_vel[0][0] <= n_vx;
        r_vel[0][1] <= n_vy;
        r_vel[0][2] <= n_tr;
        r_vel[1]    <= r_vel[0];
    end

    // tangent products
    logic signed [63:0] r_ms [3], r_mc [3], r_mfs [3], r_mfc [3], r_mrs [3];
    logic [8:0][31:0]   vt;
    assign vt = r_v[NS+3];
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_ms[k]  <= 64'(r_sp2) * 64'($signed(i_cfg.flow_select ? vt[3*k+1] : vt[3*k]));
            r_mc[k]  <= 64'(r_cp2) * 64'($signed(i_cfg.flow_select ? vt[3*k+1] : vt[3*k]));
            r_mfs[k] <= 64'(r_fs) * 64'($signed(vt[3*k+2]));
            r_mfc[k] <= 64'(r_fc) * 64'($signed(vt[3*k+2]));
            r_mrs[k] <= 64'(r_rs) * 64'($signed(vt[3*k+2]));
        end
    end

    // final sums
    logic [11:0][31:0] r_res;
    always_ff @(posedge i_clk) begin
        r_res[0] <= r_vel[1][0];
        r_res[1] <= r_vel[1][1];
        r_res[2] <= r_vel[1][2];
        for (int k = 0; k < 3; k++) begin
            if (i_cfg.flow_select) begin
                r_res[3+3*k] <= ssftr_pkg::rnd_sat(-AW'(r_ms[k]) - AW'(r_mfs[k]), 24);
                r_res[4+3*k] <= ssftr_pkg::rnd_sat(AW'(r_mfc[k]), 24);
            end else begin
                r_res[3+3*k] <= ssftr_pkg::rnd_sat(-AW'(r_mfs[k]), 24);
                r_res[4+3*k] <= ssftr_pkg::rnd_sat(-AW'(r_ms[k]) + AW'(r_mfc[k]), 24);
            end
            r_res[5+3*k] <= ssftr_pkg::rnd_sat(-(AW'(r_mrs[k]) + AW'(r_mc[k])), 25);
        end
    end

    assign o_strobe = r_vld[NS+5];
    assign o_res    = r_res;

endmodule
